FILE: rtl/lsft_pkg.sv
// Shared constants and controller/datapath interface types for the forwarding table.
package lsft_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int NUM_PORTS_DEF   = 8;
  localparam int ADDR_WIDTH_DEF  = 8;

  localparam int PORT_BITS  = 3;
  localparam int MASK_WIDTH = 8;
  localparam int CFG_WIDTH  = 4;

  localparam logic [CFG_WIDTH-1:0] ACTIVE_PORTS_RESET = CFG_WIDTH'(8);

  typedef struct packed {
    logic load_in;   // latch header, rewind scan
    logic scan;      // step the table scan
    logic key_dst;   // scan key: 0 source, 1 destination
    logic learn;     // write source if absent and room, rewind scan
    logic load_out;  // load result register
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/lsft_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/lsft_ctrl.sv
// Sequencer: source scan, learn, destination scan, result load.
module lsft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lsft_pkg::status_t status,
  output lsft_pkg::cmd_t    cmd
);
  import lsft_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRC,
    S_LEARN,
    S_DST,
    S_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (in_valid) state <= S_SRC;
        S_SRC:    if (status.scan_done) state <= S_LEARN;
        S_LEARN:  state <= S_DST;
        S_DST:    if (status.scan_done) state <= S_FINISH;
        S_FINISH: if (status.out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:   cmd.load_in = in_valid;
      S_SRC:    cmd.scan = 1'b1;
      S_LEARN:  cmd.learn = 1'b1;
      S_DST: begin
        cmd.scan    = 1'b1;
        cmd.key_dst = 1'b1;
      end
      S_FINISH: cmd.load_out = status.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

FILE: rtl/lsft_datapath.sv
// Table storage, scan compare, learning write, mask build and result register.
module lsft_datapath #(
  parameter int TABLE_DEPTH = lsft_pkg::TABLE_DEPTH_DEF,
  parameter int NUM_PORTS   = lsft_pkg::NUM_PORTS_DEF,
  parameter int ADDR_WIDTH  = lsft_pkg::ADDR_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [lsft_pkg::CFG_WIDTH-1:0]   cfg_wr_data,
  input  logic [ADDR_WIDTH-1:0]            source_addr,
  input  logic [ADDR_WIDTH-1:0]            dest_addr,
  input  logic [lsft_pkg::PORT_BITS-1:0]   ingress_port,
  input  lsft_pkg::cmd_t                   cmd,
  output lsft_pkg::status_t                status,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lsft_pkg::MASK_WIDTH-1:0]  egress_mask,
  output logic                             flooded,
  output logic                             learned,
  output logic                             learn_dropped
);
  import lsft_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = ADDR_WIDTH + PORT_BITS;

  logic [CFG_WIDTH-1:0]  active_ports;
  logic [ADDR_WIDTH-1:0] src, dst;
  logic [PORT_BITS-1:0]  port, hit_port;
  logic [CW-1:0]         fill_count, scan_idx;
  logic                  rd_pending, src_found, dst_found, learned_r, dropped_r;

  logic [EW-1:0]         rd_data;
  logic [ADDR_WIDTH-1:0] key;
  logic                  hit_now, issue, wr_en, table_full;
  logic [MASK_WIDTH-1:0] act_mask, hit_mask, self_mask;

  assign key        = cmd.key_dst ? dst : src;
  assign hit_now    = rd_pending && (rd_data[EW-1:PORT_BITS] == key);
  assign issue      = cmd.scan && (scan_idx < fill_count) && !hit_now;
  assign table_full = (fill_count == CW'(TABLE_DEPTH));
  assign wr_en      = cmd.learn && !src_found && !table_full;

  assign status.scan_done = hit_now || (!rd_pending && (scan_idx == fill_count));
  assign status.out_free  = !out_valid || out_ready;

  // valid entries are always 0 .. fill_count-1: learning only appends
  lsft_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_count[AW-1:0]),
    .wr_data ({src, port}),
    .rd_en   (issue),
    .rd_addr (scan_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active_ports <= ACTIVE_PORTS_RESET;
      fill_count   <= '0;
      rd_pending   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        active_ports <= cfg_wr_data;
      end
      if (wr_en) begin
        fill_count <= fill_count + CW'(1);
      end
      if (cmd.load_in || cmd.learn) begin
        rd_pending <= 1'b0;
      end else if (cmd.scan) begin
        rd_pending <= issue;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      src  <= source_addr;
      dst  <= dest_addr;
      port <= ingress_port;
    end
    if (cmd.load_in || cmd.learn) begin
      scan_idx <= '0;
    end else if (issue) begin
      scan_idx <= scan_idx + CW'(1);
    end
    if (cmd.learn) begin
      learned_r <= wr_en;
      dropped_r <= !src_found && table_full;
    end
    if (cmd.scan && status.scan_done) begin
      if (cmd.key_dst) begin
        dst_found <= hit_now;
        hit_port  <= rd_data[PORT_BITS-1:0];
      end else begin
        src_found <= hit_now;
      end
    end
    if (cmd.load_out) begin
      egress_mask   <= dst_found ? (hit_mask & act_mask) : (act_mask & ~self_mask);
      flooded       <= !dst_found;
      learned       <= learned_r;
      learn_dropped <= dropped_r;
    end
  end

  always_comb begin
    for (int i = 0; i < MASK_WIDTH; i++) begin
      act_mask[i]  = (CFG_WIDTH'(i) < active_ports) && (i < NUM_PORTS);
      hit_mask[i]  = (hit_port == PORT_BITS'(i));
      self_mask[i] = (port == PORT_BITS'(i));
    end
  end

endmodule

FILE: rtl/learning_switch_forward_table_unit.sv
// Top level of the learning switch forwarding table.
//
// Input channel (in_valid/in_ready) takes one header word: source_addr,
// dest_addr, ingress_port. Output channel (out_valid/out_ready) returns one
// result word per header: egress_mask, flooded, learned, learn_dropped.
// cfg_wr_en/cfg_wr_data write active_ports (reset value 8); write only idle.
//
// Per header the table is scanned linearly through one RAM read port, one
// entry per cycle: first for the source, then (after a one-cycle learn
// step) for the destination. The time from accept to result load grows with
// the number of filled entries and is less on early hits; the scans set the
// rate, and a new header is accepted only after the last result is loaded.
// The result sits in an output register, so a new header is accepted while
// the previous result waits; a stalled receiver holds the block only when
// the next result is ready to load.
//
// Reset clears the fill count (no clearing pass of the RAM), the output
// valid and sets active_ports to 8.
module learning_switch_forward_table_unit #(
  parameter int TABLE_DEPTH = lsft_pkg::TABLE_DEPTH_DEF,
  parameter int NUM_PORTS   = lsft_pkg::NUM_PORTS_DEF,
  parameter int ADDR_WIDTH  = lsft_pkg::ADDR_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [lsft_pkg::CFG_WIDTH-1:0]   cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ADDR_WIDTH-1:0]            source_addr,
  input  logic [ADDR_WIDTH-1:0]            dest_addr,
  input  logic [lsft_pkg::PORT_BITS-1:0]   ingress_port,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lsft_pkg::MASK_WIDTH-1:0]  egress_mask,
  output logic                             flooded,
  output logic                             learned,
  output logic                             learn_dropped
);
  import lsft_pkg::*;

  cmd_t    cmd;
  status_t status;

  lsft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lsft_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NUM_PORTS   (NUM_PORTS),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .source_addr   (source_addr),
    .dest_addr     (dest_addr),
    .ingress_port  (ingress_port),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .egress_mask   (egress_mask),
    .flooded       (flooded),
    .learned       (learned),
    .learn_dropped (learn_dropped)
  );

endmodule

FILE: rtl/lsft_checker.sv
// Port-level checks for the forwarding table, bound to the top level.
module lsft_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [lsft_pkg::MASK_WIDTH-1:0] egress_mask,
  input logic                            flooded,
  input logic                            learned,
  input logic                            learn_dropped
);
  import lsft_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_learn_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(learned && learn_dropped))
    else $error("learned and learn_dropped both set");

  a_hit_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !flooded |-> $onehot0(egress_mask))
    else $error("known destination sent to more than one port");

endmodule

bind learning_switch_forward_table_unit lsft_checker u_lsft_checker (.*);
